// ===== rtl/two_stack_fifo_queue_defines.svh =====
// Assertion macros used by the checker of the two-stack FIFO queue.
`ifndef TWO_STACK_FIFO_QUEUE_DEFINES_SVH
`define TWO_STACK_FIFO_QUEUE_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define TSQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside of reset.
`define TSQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tsq_pkg.sv =====
// Package with the sizes, codes and shared types of the two-stack FIFO queue.
package tsq_pkg;

   // Storage geometry of each stack.
   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Field widths fixed by the interface.
   localparam int DATA_W   = 32;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = 8;
   localparam int CAP_W    = 7;
   localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   // Operation codes.
   localparam logic [FUNC_W-1:0] FUNC_ENQUEUE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DEQUEUE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PEEK    = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;

   // Control sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_XFER,
      ST_FETCH,
      ST_RESULT
   } state_type;

   // Write and read port request for one stack memory.
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [DATA_W-1:0] wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   // Finished result handed to the output register.
   typedef struct packed {
      logic                       load;
      logic signed [DATA_W-1:0]   value;
      logic        [STATUS_W-1:0] status;
      logic        [ENTRY_W-1:0]  count;
   } result_type;

endpackage

// ===== rtl/tsq_req_if.sv =====
// Request channel interface: operation code and value to enqueue.
interface tsq_req_if;
   import tsq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic        [FUNC_W-1:0] func;
   logic signed [DATA_W-1:0] value_in;

   modport source (output valid, output func, output value_in, input ready);
   modport sink   (input valid, input func, input value_in, output ready);

endinterface

// ===== rtl/tsq_rsp_if.sv =====
// Response channel interface: value, status and total entry count.
interface tsq_rsp_if;
   import tsq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [DATA_W-1:0]   value_out;
   logic        [STATUS_W-1:0] status;
   logic        [ENTRY_W-1:0]  entry_count;

   modport source (output valid, output value_out, output status, output entry_count,
                   input ready);
   modport sink   (input valid, input value_out, input status, input entry_count,
                   output ready);

endinterface

// ===== rtl/tsq_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module tsq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tsq_ctrl.sv =====
// Control sequencer: stack counts, capacity register, refill walk and result build.
module tsq_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [tsq_pkg::CAP_W-1:0]    csr_wr_data,
   input  logic                         req_fire,
   input  logic [tsq_pkg::FUNC_W-1:0]   req_func,
   input  logic [tsq_pkg::DATA_W-1:0]   req_value,
   output logic                         req_ready,
   input  logic                         out_free,
   output tsq_pkg::result_type          result,
   output tsq_pkg::mem_req_type         in_mem,
   input  logic [tsq_pkg::DATA_W-1:0]   in_rdata,
   output tsq_pkg::mem_req_type         out_mem,
   input  logic [tsq_pkg::DATA_W-1:0]   out_rdata
);
   import tsq_pkg::*;

   state_type         state_ff, state_in;
   logic [FUNC_W-1:0] func_ff, func_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]  in_count_ff, in_count_in;
   logic [CNT_W-1:0]  out_count_ff, out_count_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [CNT_W-1:0]  xfer_rd_ff, xfer_rd_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0] wr_idx_ff, wr_idx_in;

   logic [CNT_W-1:0]  in_top;
   logic [CNT_W-1:0]  out_top;
   logic [CNT_W-1:0]  in_last;
   logic              overflow;
   logic [CNT_W:0]    count_sum;

   // Top-of-stack positions and the enqueue limit check.
   assign in_top    = in_count_ff - CNT_W'(1) - xfer_rd_ff;
   assign out_top   = out_count_ff - CNT_W'(1);
   assign in_last   = in_count_ff - CNT_W'(1);
   assign overflow  = (CMP_W'(in_count_ff) >= CMP_W'(cap_ff)) ||
                      (in_count_ff >= CNT_W'(DEPTH));
   assign count_sum = {1'b0, in_count_in} + {1'b0, out_count_in};
   assign req_ready = (state_ff == ST_IDLE);

   // State and count registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_count_ff  <= '0;
         out_count_ff <= '0;
         cap_ff       <= CAP_RESET;
         wr_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         cap_ff       <= cap_in;
         wr_pend_ff   <= wr_pend_in;
      end
   end

   // Operation and walk payload registers.
   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      value_ff   <= value_in;
      xfer_rd_ff <= xfer_rd_in;
      wr_idx_ff  <= wr_idx_in;
   end

   // Next state, memory requests and result.
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      value_in     = value_ff;
      in_count_in  = in_count_ff;
      out_count_in = out_count_ff;
      cap_in       = csr_wr_en ? csr_wr_data : cap_ff;
      xfer_rd_in   = xfer_rd_ff;
      wr_pend_in   = 1'b0;
      wr_idx_in    = xfer_rd_ff[ADDR_W-1:0];

      in_mem.we     = 1'b0;
      in_mem.waddr  = in_count_ff[ADDR_W-1:0];
      in_mem.wdata  = value_ff;
      in_mem.raddr  = in_top[ADDR_W-1:0];
      out_mem.we    = wr_pend_ff;
      out_mem.waddr = wr_idx_ff;
      out_mem.wdata = in_rdata;
      out_mem.raddr = out_top[ADDR_W-1:0];

      result.load   = 1'b0;
      result.value  = '0;
      result.status = STATUS_OK;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in  = req_func;
               value_in = req_value;
               if ((req_func == FUNC_DEQUEUE || req_func == FUNC_PEEK) &&
                   out_count_ff == '0 && in_count_ff != '0) begin
                  state_in   = ST_XFER;
                  xfer_rd_in = '0;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_XFER: begin
            // Read the input stack from the top down, write the output stack
            // from the bottom up in the following cycle.
            if (xfer_rd_ff != in_count_ff) begin
               xfer_rd_in = xfer_rd_ff + CNT_W'(1);
               wr_pend_in = 1'b1;
            end
            if (wr_pend_ff && CNT_W'(wr_idx_ff) == in_last) begin
               out_count_in = in_count_ff;
               in_count_in  = '0;
               state_in     = ST_FETCH;
            end
         end
         ST_FETCH: begin
            // The new top of the output stack is being read.
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               result.load = 1'b1;
               state_in    = ST_IDLE;
               case (func_ff)
                  FUNC_ENQUEUE: begin
                     if (overflow) begin
                        result.status = STATUS_OVERFLOW;
                     end else begin
                        in_mem.we   = 1'b1;
                        in_count_in = in_count_ff + CNT_W'(1);
                     end
                  end
                  FUNC_DEQUEUE, FUNC_PEEK: begin
                     if (out_count_ff == '0) begin
                        result.status = STATUS_EMPTY;
                     end else begin
                        result.value = out_rdata;
                        if (func_ff == FUNC_DEQUEUE) begin
                           out_count_in = out_top;
                        end
                     end
                  end
                  default: begin
                     result.status = STATUS_OK;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      result.count = ENTRY_W'(count_sum);
   end

endmodule

// ===== rtl/two_stack_fifo_queue.sv =====
// Top level of the FIFO queue built from two stack memories.
//
//   channel   direction  beat contents
//   req_chan  in         func, value_in
//   rsp_chan  out        value_out, status, entry_count
//   csr_*     in         stack_capacity write, no read-back
//
// An enqueue, a func 3 no-op, or a dequeue or peek that finds the output stack
// filled passes through the accept cycle and then the result cycle.
// A dequeue or peek that finds the output stack empty refills it first, one entry
// a cycle through the input stack's read port, then fetches the new top of stack.
// Reset clears the counts and the state; the memories are not cleared.
// A finished beat waits in the output register; one more item is accepted meanwhile
// and then holds in its result cycle until the register frees up.
module two_stack_fifo_queue (
   input  logic                        clock,
   input  logic                        reset,
   tsq_req_if.sink                     req_chan,
   tsq_rsp_if.source                   rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [tsq_pkg::CAP_W-1:0]   csr_wr_data
);
   import tsq_pkg::*;

   mem_req_type       in_mem;
   mem_req_type       out_mem;
   logic [DATA_W-1:0] in_rdata;
   logic [DATA_W-1:0] out_rdata;
   result_type        result;
   logic              req_ready;
   logic              req_fire;
   logic              out_free;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]   rsp_value_ff;
   logic        [STATUS_W-1:0] rsp_status_ff;
   logic        [ENTRY_W-1:0]  rsp_count_ff;

   // Request handshake.
   assign req_chan.ready = req_ready;
   assign req_fire       = req_chan.valid && req_ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // Sequencer.
   tsq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_fire    (req_fire),
      .req_func    (req_chan.func),
      .req_value   (req_chan.value_in),
      .req_ready   (req_ready),
      .out_free    (out_free),
      .result      (result),
      .in_mem      (in_mem),
      .in_rdata    (in_rdata),
      .out_mem     (out_mem),
      .out_rdata   (out_rdata)
   );

   // Input stack storage.
   tsq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_in_ram (
      .clock   (clock),
      .wr_en   (in_mem.we),
      .wr_addr (in_mem.waddr),
      .wr_data (in_mem.wdata),
      .rd_addr (in_mem.raddr),
      .rd_data (in_rdata)
   );

   // Output stack storage.
   tsq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_out_ram (
      .clock   (clock),
      .wr_en   (out_mem.we),
      .wr_addr (out_mem.waddr),
      .wr_data (out_mem.wdata),
      .rd_addr (out_mem.raddr),
      .rd_data (out_rdata)
   );

   // Output register valid flag.
   assign rsp_valid_in = result.load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (result.load) begin
         rsp_value_ff  <= result.value;
         rsp_status_ff <= result.status;
         rsp_count_ff  <= result.count;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.value_out   = rsp_value_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

endmodule

// ===== rtl/tsq_checker.sv =====
// Port-level checker for the two-stack FIFO queue and its bind to the top level.
`include "two_stack_fifo_queue_defines.svh"

module tsq_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [tsq_pkg::STATUS_W-1:0]   rsp_status,
   input logic [tsq_pkg::ENTRY_W-1:0]    rsp_count
);
   import tsq_pkg::*;

   logic [1:0]         pending_ff;
   logic [ENTRY_W-1:0] last_count_ff;
   logic               req_beat;
   logic               rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // Items accepted but not yet delivered, and the last delivered count.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         last_count_ff <= '0;
      end else begin
         pending_ff <= pending_ff + {1'b0, req_beat} - {1'b0, rsp_beat};
         if (rsp_beat) begin
            last_count_ff <= rsp_count;
         end
      end
   end

   // A response beat is only offered for an accepted request.
   `TSQ_ASSERT_NOW(a_rsp_has_req, clock, reset, rsp_valid, pending_ff != 2'd0, "response without request")
   // At most one item in work and one in the output register.
   `TSQ_ASSERT_NOW(a_pending_bound, clock, reset, 1'b1, pending_ff != 2'd3, "too many items in flight")
   // Each item changes the total count by at most one.
   `TSQ_ASSERT_NOW(a_count_step, clock, reset, rsp_beat, rsp_count == last_count_ff || rsp_count == last_count_ff + 8'd1 || rsp_count + 8'd1 == last_count_ff, "entry count jumped")
   // An empty status reports an empty queue and leaves it empty.
   `TSQ_ASSERT_NEXT(a_empty_zero, clock, reset, rsp_beat && rsp_status == STATUS_EMPTY, last_count_ff == 8'd0, "empty status with entries")

endmodule

bind two_stack_fifo_queue tsq_checker u_tsq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_count  (rsp_chan.entry_count)
);

// ===== tb/two_stack_fifo_queue_tb.sv =====
// Self-checking testbench for the two-stack FIFO queue: directed table, then random bursts.
module two_stack_fifo_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tsq_pkg::*;

   // The unused operation code returns a plain count beat.
   localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

   localparam int NUM_ROWS        = 26;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 190;
   localparam int SETTLE_CYCLES   = 4;
   localparam int TAIL_CYCLES     = DEPTH + 8;
   localparam int TIMEOUT_NS      = 20_000_000;

   // One result beat as the queue reports it.
   typedef struct packed {
      logic signed [DATA_W-1:0]   value;
      logic        [STATUS_W-1:0] status;
      logic        [ENTRY_W-1:0]  count;
   } queue_result_type;

   // One line of the directed table: either a capacity write or a request beat.
   typedef struct packed {
      bit                       is_csr;
      logic        [CAP_W-1:0]  csr_value;
      logic        [FUNC_W-1:0] func;
      logic signed [DATA_W-1:0] value;
      bit                       typed;
      queue_result_type         result;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;

   tsq_req_if req_bus ();
   tsq_rsp_if rsp_bus ();

   two_stack_fifo_queue u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // Predictor state: both stacks, their fill levels and the capacity setting.
   logic [DATA_W-1:0] enq_stack [DEPTH];
   logic [DATA_W-1:0] deq_stack [DEPTH];
   int                enq_fill = 0;
   int                deq_fill = 0;
   logic [CAP_W-1:0]  capacity_setting = CAP_RESET;

   queue_result_type pending_results [$];
   int               mismatch_count = 0;
   int               sender_idle_pct = 0;
   int               receiver_stall_pct = 0;

   // Sideband that travels with each request beat; a typed row overrides the predictor.
   bit               item_typed = 1'b0;
   queue_result_type item_golden = '0;

   // Directed rows: empty queue, unused code, value extremes, transfer, capacity
   // lowered below the fill level, zero capacity and capacity above the depth.
   directed_row_type directed_table [NUM_ROWS] = '{
      '{1'b0, 7'd0,   FUNC_DEQUEUE, 32'h0000_0000, 1'b1, '{32'h0, STATUS_EMPTY, 8'd0}},
      '{1'b0, 7'd0,   FUNC_PEEK,    32'h1234_5678, 1'b1, '{32'h0, STATUS_EMPTY, 8'd0}},
      '{1'b0, 7'd0,   FUNC_NOP,     32'h0000_0000, 1'b1, '{32'h0, STATUS_OK, 8'd0}},
      '{1'b0, 7'd0,   FUNC_ENQUEUE, 32'h7FFF_FFFF, 1'b1, '{32'h0, STATUS_OK, 8'd1}},
      '{1'b0, 7'd0,   FUNC_ENQUEUE, 32'h8000_0000, 1'b1, '{32'h0, STATUS_OK, 8'd2}},
      '{1'b0, 7'd0,   FUNC_ENQUEUE, 32'h0000_0000, 1'b1, '{32'h0, STATUS_OK, 8'd3}},
      '{1'b0, 7'd0,   FUNC_ENQUEUE, 32'hFFFF_FFFF, 1'b1, '{32'h0, STATUS_OK, 8'd4}},
      '{1'b0, 7'd0,   FUNC_PEEK,    32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, STATUS_OK, 8'd4}},
      '{1'b0, 7'd0,   FUNC_ENQUEUE, 32'h0000_0005, 1'b0, '0},
      '{1'b0, 7'd0,   FUNC_DEQUEUE, 32'h0000_0000, 1'b0, '0},
      '{1'b1, 7'd1,   FUNC_ENQUEUE, 32'h0000_0000, 1'b0, '0},
      '{1'b0, 7'd0,   FUNC_ENQUEUE, 32'hA5A5_A5A5, 1'b0, '0},
      '{1'b1, 7'd0,   FUNC_ENQUEUE, 32'h0000_0000, 1'b0, '0},
      '{1'b0, 7'd0,   FUNC_ENQUEUE, 32'h5A5A_5A5A, 1'b0, '0},
      '{1'b0, 7'd0,   FUNC_DEQUEUE, 32'h0000_0000, 1'b0, '0},
      '{1'b0, 7'd0,   FUNC_DEQUEUE, 32'hFFFF_FFFF, 1'b0, '0},
      '{1'b0, 7'd0,   FUNC_DEQUEUE, 32'h0000_0000, 1'b0, '0},
      '{1'b0, 7'd0,   FUNC_DEQUEUE, 32'h0000_0000, 1'b0, '0},
      '{1'b0, 7'd0,   FUNC_DEQUEUE, 32'h0000_0000, 1'b1, '{32'h0, STATUS_EMPTY, 8'd0}},
      '{1'b0, 7'd0,   FUNC_ENQUEUE, 32'hFFFF_0000, 1'b1, '{32'h0, STATUS_OVERFLOW, 8'd0}},
      '{1'b1, 7'd127, FUNC_ENQUEUE, 32'h0000_0000, 1'b0, '0},
      '{1'b0, 7'd0,   FUNC_ENQUEUE, 32'h0000_0001, 1'b0, '0},
      '{1'b0, 7'd0,   FUNC_NOP,     32'hFFFF_FFFF, 1'b0, '0},
      '{1'b0, 7'd0,   FUNC_PEEK,    32'h0000_0000, 1'b0, '0},
      '{1'b0, 7'd0,   FUNC_DEQUEUE, 32'h0000_0000, 1'b0, '0},
      '{1'b1, 7'd64,  FUNC_ENQUEUE, 32'h0000_0000, 1'b0, '0}
   };

   // Computes the beat for one accepted request and advances the predictor state.
   function automatic queue_result_type predict_queue_op(logic [FUNC_W-1:0] f,
                                                         logic [DATA_W-1:0] v);
      queue_result_type r;
      int               limit;
      r = '0;
      r.status = STATUS_OK;
      limit = (int'(capacity_setting) > DEPTH) ? DEPTH : int'(capacity_setting);
      case (f)
         FUNC_ENQUEUE: begin
            if (enq_fill >= limit) begin
               r.status = STATUS_OVERFLOW;
            end else begin
               enq_stack[enq_fill] = v;
               enq_fill++;
            end
         end
         FUNC_DEQUEUE, FUNC_PEEK: begin
            // An empty output stack takes every input entry, reversed.
            if (deq_fill == 0) begin
               for (int k = 0; k < enq_fill; k++) begin
                  deq_stack[k] = enq_stack[enq_fill - 1 - k];
               end
               deq_fill = enq_fill;
               enq_fill = 0;
            end
            if (deq_fill == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.value = deq_stack[deq_fill - 1];
               if (f == FUNC_DEQUEUE) begin
                  deq_fill--;
               end
            end
         end
         default: ;
      endcase
      r.count = ENTRY_W'(enq_fill + deq_fill);
      return r;
   endfunction

   // Check response beats against the oldest expectation, then predict new requests.
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("response beat with no expectation: value_out %h status %0d count %0d",
                   rsp_bus.value_out, rsp_bus.status, rsp_bus.entry_count);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.value_out !== want.value) begin
               $error("value_out expected %h actual %h", want.value, rsp_bus.value_out);
               mismatch_count++;
            end
            if (rsp_bus.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_bus.status);
               mismatch_count++;
            end
            if (rsp_bus.entry_count !== want.count) begin
               $error("entry_count expected %0d actual %0d", want.count,
                      rsp_bus.entry_count);
               mismatch_count++;
            end
         end
      end
      if (!reset && req_bus.valid && req_bus.ready) begin
         want = predict_queue_op(req_bus.func, req_bus.value_in);
         pending_results.push_back(item_typed ? item_golden : want);
      end
   end

   // Receiver: ready is redrawn every cycle from the current stall rate.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Sends one request beat after a random idle gap and returns once it is accepted.
   task automatic send_request(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] v,
                               input bit typed, input queue_result_type golden);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.func     <= f;
      req_bus.value_in <= v;
      item_typed       <= typed;
      item_golden      <= golden;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Lets the queue drain completely, then writes the capacity register.
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      capacity_setting = cap;
   endtask

   // Stimulus: reset, directed table, then random bursts over several phases.
   initial begin
      int                issued;
      int                pick;
      int                run_len;
      logic [FUNC_W-1:0] f;
      logic [DATA_W-1:0] v;
      logic [CAP_W-1:0]  cap;

      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.func     <= FUNC_NOP;
      req_bus.value_in <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, run back to back with no idling.
      foreach (directed_table[i]) begin
         if (directed_table[i].is_csr) begin
            write_capacity(directed_table[i].csr_value);
         end else begin
            send_request(directed_table[i].func, directed_table[i].value,
                         directed_table[i].typed, directed_table[i].result);
         end
      end

      // Random part: each phase picks a capacity and an idling pattern.
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0:       cap = 7'd127;
            1:       cap = 7'd1;
            2:       cap = 7'd64;
            3:       cap = 7'd0;
            4:       cap = CAP_W'($urandom_range(10, 2));
            5:       cap = 7'd127;
            6:       cap = CAP_W'($urandom_range(127, 1));
            default: cap = 7'd64;
         endcase
         write_capacity(cap);
         case (p % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 70;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 70;
            end
            default: begin
               sender_idle_pct    = 19;
               receiver_stall_pct = 19;
            end
         endcase

         // Long enqueue runs fill the stacks to capacity, long drain runs force
         // transfers and empty hits, short mixed runs cover the unused code.
         issued = 0;
         while (issued < ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            run_len = (pick < 75) ? $urandom_range(70, 1) : $urandom_range(16, 1);
            for (int k = 0; k < run_len && issued < ITEMS_PER_PHASE; k++) begin
               if (pick < 40) begin
                  f = FUNC_ENQUEUE;
               end else if (pick < 75) begin
                  f = ($urandom_range(3) == 0) ? FUNC_PEEK : FUNC_DEQUEUE;
               end else begin
                  f = FUNC_W'($urandom_range(3));
               end
               case ($urandom_range(15))
                  0:       v = 32'h7FFF_FFFF;
                  1:       v = 32'h8000_0000;
                  2:       v = 32'h0000_0000;
                  3:       v = 32'hFFFF_FFFF;
                  default: v = $urandom;
               endcase
               send_request(f, v, 1'b0, '0);
               issued++;
            end
         end
      end

      // Wait for the last beats, then watch a while for stray responses.
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
